@@ src/rmpu_pkg.sv @@
// Shared constants and types for the region memory protection unit.
package rmpu_pkg;

    localparam int DEF_ENTRIES    = 4;
    localparam int DEF_MAX_PAGES  = 16;
    localparam int DEF_PAGE_SHIFT = 12;

    localparam int ADDR_WIDTH   = 32;
    localparam int CMD_WIDTH    = 3;
    localparam int LEN_WIDTH    = 17;
    localparam int PROT_WIDTH   = 3;
    localparam int SIZE_WIDTH   = 2;
    localparam int STATUS_WIDTH = 2;
    localparam int REGION_WIDTH = 2;
    localparam int OFFSET_WIDTH = 16;

    localparam int PERM_R_BIT = 0;
    localparam int PERM_W_BIT = 1;
    localparam int PERM_X_BIT = 2;

    typedef enum logic [CMD_WIDTH-1:0] {
        CMD_MAP   = 3'd0,
        CMD_UNMAP = 3'd1,
        CMD_READ  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_FETCH = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_OK     = 2'd0,
        ST_SEGV   = 2'd1,
        ST_PROT   = 2'd2,
        ST_REJECT = 2'd3
    } t_status;

endpackage

@@ src/region_memory_protection_unit_core.sv @@
// Region memory protection unit: region table, map/unmap and access checking.
// A transaction accepted into the input register is checked there, and its result is
// registered in the result register that drives the output ports, marked by o_valid.
// Throughput: one transaction per cycle; busy is never raised, since the table is updated in
// the same cycle that checks each transaction, so the next one always sees the updated table.
// Reset (synchronous, active low) frees every region and clears all page valid bits.
module region_memory_protection_unit_core #(
    parameter int ENTRIES    = rmpu_pkg::DEF_ENTRIES,
    parameter int MAX_PAGES  = rmpu_pkg::DEF_MAX_PAGES,
    parameter int PAGE_SHIFT = rmpu_pkg::DEF_PAGE_SHIFT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [rmpu_pkg::CMD_WIDTH-1:0]    i_cmd,
    input  logic [rmpu_pkg::ADDR_WIDTH-1:0]   i_addr,
    input  logic [rmpu_pkg::LEN_WIDTH-1:0]    i_length,
    input  logic [rmpu_pkg::PROT_WIDTH-1:0]   i_prot,
    input  logic [rmpu_pkg::SIZE_WIDTH-1:0]   i_access_size,
    output logic                              o_valid,
    output logic [rmpu_pkg::STATUS_WIDTH-1:0] o_status,
    output logic [rmpu_pkg::REGION_WIDTH-1:0] o_region,
    output logic [rmpu_pkg::OFFSET_WIDTH-1:0] o_offset,
    output logic [rmpu_pkg::ADDR_WIDTH-1:0]   o_mapped_base,
    output logic [rmpu_pkg::PROT_WIDTH-1:0]   o_perms
);
    import rmpu_pkg::*;

    // Derived widths.
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PN_W  = ADDR_WIDTH - PAGE_SHIFT;
    localparam int CNT_W = $clog2(MAX_PAGES + 1);
    localparam int PG_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int PL_W  = LEN_WIDTH + 1;
    localparam int END_W = ADDR_WIDTH + 1;
    localparam logic [PL_W-1:0] PAGE_M1 = PL_W'((1 << PAGE_SHIFT) - 1);

    // Input register.
    logic                  r_in_valid;
    logic [CMD_WIDTH-1:0]  r_cmd;
    logic [ADDR_WIDTH-1:0] r_addr;
    logic [LEN_WIDTH-1:0]  r_length;
    logic [PROT_WIDTH-1:0] r_prot;
    logic [SIZE_WIDTH-1:0] r_size;

    // Region table.
    logic [ENTRIES-1:0]    r_used;
    logic [PN_W-1:0]       r_base_page [ENTRIES];
    logic [CNT_W-1:0]      r_count     [ENTRIES];
    logic [PROT_WIDTH-1:0] r_perm      [ENTRIES];
    logic [MAX_PAGES-1:0]  r_pvalid    [ENTRIES];

    // Result register.
    logic                    r_out_valid;
    t_status                 r_status;
    logic [REGION_WIDTH-1:0] r_region;
    logic [OFFSET_WIDTH-1:0] r_offset;
    logic [ADDR_WIDTH-1:0]   r_mbase;
    logic [PROT_WIDTH-1:0]   r_perms;

    // The whole table is checked in parallel, so the block never needs to stall.
    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_cmd    <= i_cmd;
            r_addr   <= i_addr;
            r_length <= i_length;
            r_prot   <= i_prot;
            r_size   <= i_access_size;
        end
    end

    // Address split into page number and byte within the page.
    logic [PN_W-1:0]       a_page;
    logic [PAGE_SHIFT-1:0] a_low;
    assign a_page = r_addr[ADDR_WIDTH-1:PAGE_SHIFT];
    assign a_low  = r_addr[PAGE_SHIFT-1:0];

    // Region lookup: every entry is compared at once, the lowest index wins.
    logic [PN_W-1:0]    dpage [ENTRIES];
    logic [ENTRIES-1:0] hit;
    logic               hit_any;
    logic [IDX_W-1:0]   hit_idx;
    logic               free_any;
    logic [IDX_W-1:0]   free_idx;

    always_comb begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            dpage[i] = a_page - r_base_page[i];
            hit[i]   = r_used[i] && (a_page >= r_base_page[i]) &&
                       (dpage[i] < PN_W'(r_count[i]));
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (hit[i]) begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (!r_used[i]) begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    logic [PN_W-1:0]       sel_dp;
    logic [CNT_W-1:0]      sel_cnt;
    logic [PROT_WIDTH-1:0] sel_perm;
    logic [MAX_PAGES-1:0]  sel_pvalid;
    logic [ADDR_WIDTH-1:0] sel_off;

    assign sel_dp     = dpage[hit_idx];
    assign sel_cnt    = r_count[hit_idx];
    assign sel_perm   = r_perm[hit_idx];
    assign sel_pvalid = r_pvalid[hit_idx];
    assign sel_off    = {sel_dp, a_low};

    // Access check. The access can only run past the region end on its last page,
    // and since a page is far larger than eight bytes at most one page boundary is crossed.
    logic [3:0]          size_bytes;
    logic [PAGE_SHIFT:0] low_sum;
    logic                past_end;
    logic                page_ok;
    logic                perm_bad;

    always_comb begin
        size_bytes = 4'd1 << r_size;
        low_sum    = {1'b0, a_low} + (PAGE_SHIFT + 1)'(size_bytes);
        past_end   = (sel_dp == (PN_W'(sel_cnt) - PN_W'(1))) && low_sum[PAGE_SHIFT] &&
                     (low_sum[PAGE_SHIFT-1:0] != '0);
        page_ok    = sel_pvalid[sel_dp[PG_W-1:0]];
        case (r_cmd)
            CMD_READ:  perm_bad = !sel_perm[PERM_R_BIT];
            CMD_WRITE: perm_bad = !sel_perm[PERM_W_BIT];
            CMD_FETCH: perm_bad = !sel_perm[PERM_R_BIT] || !sel_perm[PERM_X_BIT];
            default:   perm_bad = 1'b0;
        endcase
    end

    // Map: round the length up to pages, build the permission set and the valid mask.
    logic [PL_W-1:0]       pages_sum;
    logic [PL_W-1:0]       pages;
    logic                  map_ok;
    logic [PROT_WIDTH-1:0] map_perm;
    logic [MAX_PAGES-1:0]  map_pvalid;

    always_comb begin
        pages_sum = {1'b0, r_length} + PAGE_M1;
        pages     = pages_sum >> PAGE_SHIFT;
        map_ok    = (r_length != '0) && (pages <= PL_W'(MAX_PAGES)) && free_any;
        map_perm  = '0;
        map_perm[PERM_R_BIT] = |r_prot;
        map_perm[PERM_W_BIT] = r_prot[PERM_W_BIT];
        map_perm[PERM_X_BIT] = r_prot[PERM_X_BIT];
        for (int k = 0; k < MAX_PAGES; k++) begin
            map_pvalid[k] = PL_W'(k) < pages;
        end
    end

    // Unmap: clear pages from the one holding the start up to the one holding the last byte.
    logic [END_W-1:0]     end_page;
    logic [MAX_PAGES-1:0] unmap_pvalid;
    logic                 unmap_go;

    always_comb begin
        end_page = ({1'b0, sel_off} + END_W'(r_length) - END_W'(1)) >> PAGE_SHIFT;
        unmap_go = hit_any && (r_length != '0);
        for (int k = 0; k < MAX_PAGES; k++) begin
            unmap_pvalid[k] = sel_pvalid[k] &&
                              !((PN_W'(k) >= sel_dp) && (END_W'(k) <= end_page));
        end
    end

    // Result of the transaction in the input register.
    t_status               n_status;
    logic [IDX_W-1:0]      n_idx;
    logic [ADDR_WIDTH-1:0] n_offset;
    logic [ADDR_WIDTH-1:0] n_mbase;
    logic [PROT_WIDTH-1:0] n_perms;

    always_comb begin
        n_status = ST_OK;
        n_idx    = '0;
        n_offset = '0;
        n_mbase  = '0;
        n_perms  = '0;
        case (r_cmd)
            CMD_MAP: begin
                if (map_ok) begin
                    n_idx   = free_idx;
                    n_mbase = {a_page, {PAGE_SHIFT{1'b0}}};
                    n_perms = map_perm;
                end else begin
                    n_status = ST_REJECT;
                end
            end
            CMD_UNMAP: begin
                if (hit_any) begin
                    n_idx = hit_idx;
                end
            end
            CMD_READ, CMD_WRITE, CMD_FETCH: begin
                if (!hit_any || past_end || !page_ok) begin
                    n_status = ST_SEGV;
                end else begin
                    n_status = perm_bad ? ST_PROT : ST_OK;
                    n_idx    = hit_idx;
                    n_offset = sel_off;
                    n_perms  = sel_perm;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    logic [IDX_W+REGION_WIDTH-1:0] idx_ext;
    assign idx_ext = {{REGION_WIDTH{1'b0}}, n_idx};

    // Table control state: in-use flags and page valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_pvalid[i] <= '0;
            end
        end else if (r_in_valid) begin
            if (r_cmd == CMD_MAP && map_ok) begin
                r_used[free_idx]   <= 1'b1;
                r_pvalid[free_idx] <= map_pvalid;
            end else if (r_cmd == CMD_UNMAP && unmap_go) begin
                r_pvalid[hit_idx] <= unmap_pvalid;
                if (unmap_pvalid == '0) begin
                    r_used[hit_idx] <= 1'b0;
                end
            end
        end
    end

    // Table payload, written only by a successful map.
    always_ff @(posedge i_clk) begin
        if (r_in_valid && r_cmd == CMD_MAP && map_ok) begin
            r_base_page[free_idx] <= a_page;
            r_count[free_idx]     <= pages[CNT_W-1:0];
            r_perm[free_idx]      <= map_perm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_status <= n_status;
            r_region <= idx_ext[REGION_WIDTH-1:0];
            r_offset <= n_offset[OFFSET_WIDTH-1:0];
            r_mbase  <= n_mbase;
            r_perms  <= n_perms;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_region      = r_region;
    assign o_offset      = r_offset;
    assign o_mapped_base = r_mbase;
    assign o_perms       = r_perms;

    // Every accepted transaction produces its result, marked by o_valid.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("accepted transaction produced no result");

    // An entry is in use exactly when at least one of its pages is valid.
    for (genvar g = 0; g < ENTRIES; g++) begin : g_used_chk
        a_used_matches_pages: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_used[g] == (r_pvalid[g] != '0))
            else $error("entry in-use flag disagrees with its page valid bits");
    end

    // A segmentation fault or a rejected map carries no region details.
    a_fault_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_SEGV || o_status == ST_REJECT)) |->
        (o_region == '0 && o_offset == '0 && o_perms == '0 && o_mapped_base == '0))
        else $error("fault result carries region details");

endmodule

@@ sim/tb_region_memory_protection_unit_core.sv @@
// Self-checking testbench for the region memory protection unit core.
`timescale 1ns / 1ps

module tb_region_memory_protection_unit_core;
    import rmpu_pkg::*;

    // The block is built with its default geometry, so the shadow table uses the same numbers.
    localparam int NUM_REGIONS = DEF_ENTRIES;
    localparam int MAX_PAGES   = DEF_MAX_PAGES;
    localparam int PAGE_SHIFT  = DEF_PAGE_SHIFT;
    localparam int PAGE_NUM_W  = ADDR_WIDTH - PAGE_SHIFT;
    localparam logic [63:0] PAGE_BYTES = 64'd1 << PAGE_SHIFT;

    // Command codes above the fetch code are reserved; the block must answer them with zeros.
    localparam logic [CMD_WIDTH-1:0] CMD_RSVD_LO = 3'd5;
    localparam logic [CMD_WIDTH-1:0] CMD_RSVD_HI = 3'd7;

    localparam logic [PROT_WIDTH-1:0] PROT_R = PROT_WIDTH'(1 << PERM_R_BIT);
    localparam logic [PROT_WIDTH-1:0] PROT_W = PROT_WIDTH'(1 << PERM_W_BIT);
    localparam logic [PROT_WIDTH-1:0] PROT_X = PROT_WIDTH'(1 << PERM_X_BIT);

    localparam int RANDOM_ITEMS = 1200;
    localparam int PERCENT_IDLE = 31;

    typedef struct packed {
        t_status                 status;
        logic [REGION_WIDTH-1:0] region;
        logic [OFFSET_WIDTH-1:0] offset;
        logic [ADDR_WIDTH-1:0]   mapped_base;
        logic [PROT_WIDTH-1:0]   perms;
    } t_verdict;

    typedef struct packed {
        logic [CMD_WIDTH-1:0]  cmd;
        logic [ADDR_WIDTH-1:0] addr;
        logic [LEN_WIDTH-1:0]  length;
        logic [PROT_WIDTH-1:0] prot;
        logic [SIZE_WIDTH-1:0] size_code;
    } t_txn;

    // One line of the directed script. When fixed is set, want is the verdict to expect;
    // otherwise the verdict comes from the region table model below.
    typedef struct packed {
        t_txn     txn;
        logic     fixed;
        t_verdict want;
    } t_script_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [CMD_WIDTH-1:0]    i_cmd;
    logic [ADDR_WIDTH-1:0]   i_addr;
    logic [LEN_WIDTH-1:0]    i_length;
    logic [PROT_WIDTH-1:0]   i_prot;
    logic [SIZE_WIDTH-1:0]   i_access_size;
    logic                    o_valid;
    logic [STATUS_WIDTH-1:0] o_status;
    logic [REGION_WIDTH-1:0] o_region;
    logic [OFFSET_WIDTH-1:0] o_offset;
    logic [ADDR_WIDTH-1:0]   o_mapped_base;
    logic [PROT_WIDTH-1:0]   o_perms;

    // Model of the region table, kept in step with the block one transaction at a time.
    logic                  rgn_used      [NUM_REGIONS];
    logic [PAGE_NUM_W-1:0] rgn_base_page [NUM_REGIONS];
    logic [7:0]            rgn_pages     [NUM_REGIONS];
    logic [PROT_WIDTH-1:0] rgn_perms     [NUM_REGIONS];
    logic [MAX_PAGES-1:0]  rgn_valid     [NUM_REGIONS];

    // Verdicts of accepted transactions whose result has not come out yet, oldest first.
    t_verdict expected_verdicts[$];
    int       fail_count = 0;
    logic     idle_on;

    region_memory_protection_unit_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_addr        (i_addr),
        .i_length      (i_length),
        .i_prot        (i_prot),
        .i_access_size (i_access_size),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_region      (o_region),
        .o_offset      (o_offset),
        .o_mapped_base (o_mapped_base),
        .o_perms       (o_perms)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs or drops results.
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic void free_region(input int i);
        rgn_used[i]      = 1'b0;
        rgn_base_page[i] = '0;
        rgn_pages[i]     = '0;
        rgn_perms[i]     = '0;
        rgn_valid[i]     = '0;
    endfunction

    function automatic logic [63:0] region_base(input int i);
        return 64'({rgn_base_page[i], {PAGE_SHIFT{1'b0}}});
    endfunction

    function automatic logic [63:0] region_span(input int i);
        return 64'(rgn_pages[i]) << PAGE_SHIFT;
    endfunction

    // First in-use region that holds the address, or -1. Lower entries win on overlap.
    function automatic int lookup_region(input logic [63:0] a, output logic [63:0] off);
        off = '0;
        for (int i = 0; i < NUM_REGIONS; i++) begin
            if (rgn_used[i] && a >= region_base(i) && (a - region_base(i)) < region_span(i)) begin
                off = a - region_base(i);
                return i;
            end
        end
        return -1;
    endfunction

    // Works out the verdict of one transaction and applies its effect on the region table.
    function automatic t_verdict predict_verdict(input t_txn t);
        t_verdict              v;
        logic [63:0]           a;
        logic [63:0]           len;
        logic [63:0]           pages;
        logic [63:0]           off;
        logic [63:0]           stop_byte;
        logic [63:0]           ps;
        logic [PROT_WIDTH-1:0] p;
        int                    slot;
        int                    r;
        logic                  denied;
        v   = '0;
        a   = 64'(t.addr);
        len = 64'(t.length);
        case (t.cmd)
            CMD_MAP: begin
                // The length is rounded up to whole pages; the first free entry takes the region.
                pages = (len + PAGE_BYTES - 1) >> PAGE_SHIFT;
                slot  = -1;
                for (int i = NUM_REGIONS - 1; i >= 0; i--) begin
                    if (!rgn_used[i]) slot = i;
                end
                if (len == 0 || pages > MAX_PAGES || slot < 0) begin
                    v.status = ST_REJECT;
                end else begin
                    // Write and execute each bring read along with them.
                    p             = '0;
                    p[PERM_R_BIT] = |t.prot;
                    p[PERM_W_BIT] = t.prot[PERM_W_BIT];
                    p[PERM_X_BIT] = t.prot[PERM_X_BIT];
                    rgn_used[slot]      = 1'b1;
                    rgn_base_page[slot] = t.addr[ADDR_WIDTH-1:PAGE_SHIFT];
                    rgn_pages[slot]     = pages[7:0];
                    rgn_perms[slot]     = p;
                    rgn_valid[slot]     = {MAX_PAGES{1'b1}} >> (MAX_PAGES - int'(pages));
                    v.region            = REGION_WIDTH'(slot);
                    v.mapped_base       = {t.addr[ADDR_WIDTH-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
                    v.perms             = p;
                end
            end
            CMD_UNMAP: begin
                // Clear every page of the hit region that overlaps the byte range; the entry
                // is freed when no valid page is left. A miss or a zero length changes nothing.
                r = lookup_region(a, off);
                if (r >= 0) begin
                    v.region = REGION_WIDTH'(r);
                    if (len != 0) begin
                        stop_byte = off + len;
                        for (int k = 0; k < MAX_PAGES; k++) begin
                            ps = 64'(k) << PAGE_SHIFT;
                            if (k < rgn_pages[r] && ps < stop_byte && ps + PAGE_BYTES > off)
                                rgn_valid[r][k] = 1'b0;
                        end
                        if (rgn_valid[r] == '0) free_region(r);
                    end
                end
            end
            CMD_READ, CMD_WRITE, CMD_FETCH: begin
                // Only the page that holds the first byte has its valid bit checked.
                r = lookup_region(a, off);
                if (r < 0 || off + (64'd1 << t.size_code) > region_span(r) ||
                    !rgn_valid[r][off >> PAGE_SHIFT]) begin
                    v.status = ST_SEGV;
                end else begin
                    p = rgn_perms[r];
                    case (t.cmd)
                        CMD_READ:  denied = !p[PERM_R_BIT];
                        CMD_WRITE: denied = !p[PERM_W_BIT];
                        default:   denied = !p[PERM_R_BIT] || !p[PERM_X_BIT];
                    endcase
                    if (denied) v.status = ST_PROT;
                    else        v.status = ST_OK;
                    v.region = REGION_WIDTH'(r);
                    v.offset = off[OFFSET_WIDTH-1:0];
                    v.perms  = p;
                end
            end
            default: ;
        endcase
        return v;
    endfunction

    function automatic t_script_row script_row(input logic fixed, input t_status status,
                                               input logic [CMD_WIDTH-1:0] cmd,
                                               input logic [ADDR_WIDTH-1:0] addr,
                                               input logic [LEN_WIDTH-1:0] len,
                                               input logic [PROT_WIDTH-1:0] prot,
                                               input logic [SIZE_WIDTH-1:0] size_code);
        t_script_row row;
        row                = '0;
        row.txn.cmd        = cmd;
        row.txn.addr       = addr;
        row.txn.length     = len;
        row.txn.prot       = prot;
        row.txn.size_code  = size_code;
        row.fixed          = fixed;
        row.want.status    = status;
        return row;
    endfunction

    // Addresses clustered around a few page groups, so that regions overlap now and then,
    // with the top of the address space and fully random pages mixed in.
    function automatic logic [ADDR_WIDTH-1:0] pool_addr();
        logic [PAGE_NUM_W-1:0] pg;
        case ($urandom_range(3))
            0:       pg = '0;
            1:       pg = PAGE_NUM_W'(MAX_PAGES);
            2:       pg = '1 - PAGE_NUM_W'(MAX_PAGES - 1);
            default: pg = PAGE_NUM_W'($urandom);
        endcase
        pg = pg + PAGE_NUM_W'($urandom_range(0, MAX_PAGES - 1));
        return {pg, PAGE_SHIFT'($urandom)};
    endfunction

    // Random transaction, mostly aimed at regions that are mapped right now so that the
    // accesses get past the lookup and reach the page and permission checks.
    function automatic t_txn random_txn();
        t_txn        t;
        int          live[$];
        int          r;
        int          pick;
        logic [63:0] span;
        logic [63:0] off;
        t.cmd       = CMD_READ;
        t.addr      = $urandom;
        t.length    = LEN_WIDTH'($urandom);
        t.prot      = PROT_WIDTH'($urandom);
        t.size_code = SIZE_WIDTH'($urandom);
        for (int i = 0; i < NUM_REGIONS; i++) begin
            if (rgn_used[i]) live.push_back(i);
        end
        r    = (live.size() != 0) ? live[$urandom_range(live.size() - 1)] : -1;
        pick = $urandom_range(99);
        if (pick < 14) begin
            t.cmd  = CMD_MAP;
            t.addr = pool_addr();
            // Small regions most of the time; the largest and the rejected lengths now and then.
            case ($urandom_range(19))
                0:       t.length = '0;
                1:       t.length = LEN_WIDTH'($urandom_range(MAX_PAGES * PAGE_BYTES + 1, 131071));
                2:       t.length = LEN_WIDTH'(MAX_PAGES * PAGE_BYTES);
                3, 4, 5: t.length = LEN_WIDTH'($urandom_range(1, MAX_PAGES * PAGE_BYTES));
                default: t.length = LEN_WIDTH'($urandom_range(1, 4 * PAGE_BYTES));
            endcase
        end else if (pick < 24) begin
            t.cmd = CMD_UNMAP;
            if (r >= 0 && $urandom_range(99) < 85) begin
                span   = region_span(r);
                t.addr = ADDR_WIDTH'(region_base(r) + $urandom_range(0, span - 1));
                case ($urandom_range(9))
                    0:       t.length = '0;
                    1, 2, 3: t.length = LEN_WIDTH'(span);
                    4:       t.length = LEN_WIDTH'($urandom);
                    default: t.length = LEN_WIDTH'($urandom_range(1, 3 * PAGE_BYTES));
                endcase
            end else begin
                t.addr   = pool_addr();
                t.length = LEN_WIDTH'($urandom_range(0, MAX_PAGES * PAGE_BYTES));
            end
        end else if (pick < 90) begin
            t.cmd = CMD_WIDTH'($urandom_range(CMD_READ, CMD_FETCH));
            if (r >= 0 && $urandom_range(99) < 80) begin
                span = region_span(r);
                // Hit the last bytes and the first bytes past the end as well as the middle.
                case ($urandom_range(3))
                    0:       off = span - $urandom_range(1, 8);
                    1:       off = span + $urandom_range(0, 8);
                    default: off = $urandom_range(0, span - 1);
                endcase
                t.addr = ADDR_WIDTH'(region_base(r) + off);
            end else if ($urandom_range(1)) begin
                t.addr = pool_addr();
            end
        end else if (pick < 93) begin
            t.cmd = CMD_WIDTH'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
        end else begin
            // Noise: any valid command with fully random fields.
            t.cmd = CMD_WIDTH'($urandom_range(CMD_MAP, CMD_FETCH));
        end
        return t;
    endfunction

    // Presents one transaction, with random idle cycles ahead of it, and holds it until the
    // block takes it. The verdict is queued at the edge that accepts the transaction.
    task automatic run_transaction(input t_txn t, input logic fixed, input t_verdict want);
        t_verdict v;
        while (idle_on && $urandom_range(99) < PERCENT_IDLE) begin
            // Idle cycle: start is low and the payload carries junk that must be ignored.
            start         <= 1'b0;
            i_cmd         <= CMD_WIDTH'($urandom);
            i_addr        <= $urandom;
            i_length      <= LEN_WIDTH'($urandom);
            i_prot        <= PROT_WIDTH'($urandom);
            i_access_size <= SIZE_WIDTH'($urandom);
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_cmd         <= t.cmd;
        i_addr        <= t.addr;
        i_length      <= t.length;
        i_prot        <= t.prot;
        i_access_size <= t.size_code;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        v = predict_verdict(t);
        if (fixed) expected_verdicts.push_back(want);
        else       expected_verdicts.push_back(v);
    endtask

    // Stops sending and waits until every outstanding result has come back.
    task automatic wait_for_drain();
        start <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge i_clk);
    endtask

    function automatic string show(input t_verdict v);
        return $sformatf("status=%0d region=%0d offset=%h base=%h perms=%0d",
                         v.status, v.region, v.offset, v.mapped_base, v.perms);
    endfunction

    function automatic void log_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("mismatch %0d: %s", fail_count, msg);
    endfunction

    // Every result strobe is matched against the oldest outstanding verdict, field by field.
    // The receiver cannot stall the block, so results are taken at every edge that shows one.
    always @(posedge i_clk) begin : result_check
        t_verdict got;
        t_verdict want;
        if (i_rst_n === 1'b1 && o_valid !== 1'b0) begin
            got.status      = t_status'(o_status);
            got.region      = o_region;
            got.offset      = o_offset;
            got.mapped_base = o_mapped_base;
            got.perms       = o_perms;
            if (expected_verdicts.size() == 0) begin
                log_failure({"result with no transaction outstanding: ", show(got)});
            end else begin
                want = expected_verdicts.pop_front();
                if (got.status !== want.status || got.region !== want.region ||
                    got.offset !== want.offset || got.mapped_base !== want.mapped_base ||
                    got.perms !== want.perms)
                    log_failure({"expected ", show(want), " got ", show(got)});
            end
        end
    end

    initial begin
        t_script_row script[$];
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_cmd         = '0;
        i_addr        = '0;
        i_length      = '0;
        i_prot        = '0;
        i_access_size = '0;
        idle_on       = 1'b1;
        for (int i = 0; i < NUM_REGIONS; i++) free_region(i);

        // Directed script. Rows with a fixed verdict are the ones whose answer is plain:
        // an empty table, rejected maps, and the reserved command codes.
        // Empty table: every access misses.
        script.push_back(script_row(1'b1, ST_SEGV, CMD_READ, '0, '0, '0, 2'd0));
        script.push_back(script_row(1'b1, ST_SEGV, CMD_FETCH, '1, '1, '1, 2'd3));
        // Zero length and one page too many are both refused.
        script.push_back(script_row(1'b1, ST_REJECT, CMD_MAP, 32'h0000_5000, '0, '1, 2'd0));
        script.push_back(script_row(1'b1, ST_REJECT, CMD_MAP, 32'h0000_5000,
                                    LEN_WIDTH'(MAX_PAGES * PAGE_BYTES + 1), '1, 2'd0));
        // Fill the table: an unaligned one-byte region, the top page of the address space,
        // the largest region, and one without any permission.
        script.push_back(script_row(1'b0, ST_OK, CMD_MAP, 32'h0000_1234, 17'd1, PROT_R, 2'd0));
        script.push_back(script_row(1'b0, ST_OK, CMD_MAP, 32'hFFFF_F000,
                                    LEN_WIDTH'(PAGE_BYTES), PROT_W, 2'd0));
        script.push_back(script_row(1'b0, ST_OK, CMD_MAP, 32'h0010_0000,
                                    LEN_WIDTH'(MAX_PAGES * PAGE_BYTES), PROT_X, 2'd0));
        script.push_back(script_row(1'b0, ST_OK, CMD_MAP, 32'h0020_0000,
                                    LEN_WIDTH'(2 * PAGE_BYTES), '0, 2'd0));
        // Table full.
        script.push_back(script_row(1'b1, ST_REJECT, CMD_MAP, 32'h0030_0000, 17'd100,
                                    PROT_R | PROT_W | PROT_X, 2'd0));
        // Last byte of a region, then a two-byte access that runs past its end.
        script.push_back(script_row(1'b0, ST_OK, CMD_READ, 32'h0000_1FFF, '0, '0, 2'd0));
        script.push_back(script_row(1'b0, ST_OK, CMD_READ, 32'h0000_1FFF, '0, '0, 2'd1));
        // Read-only region: write and fetch are both protection faults.
        script.push_back(script_row(1'b0, ST_OK, CMD_WRITE, 32'h0000_1000, '0, '0, 2'd2));
        script.push_back(script_row(1'b0, ST_OK, CMD_FETCH, 32'h0000_1000, '0, '0, 2'd0));
        // Eight-byte write ending exactly at the top of the address space.
        script.push_back(script_row(1'b0, ST_OK, CMD_WRITE, 32'hFFFF_FFF8, '0, '0, 2'd3));
        script.push_back(script_row(1'b0, ST_OK, CMD_FETCH, 32'h0010_FFFF, '0, '0, 2'd0));
        // A region with no permissions refuses even a read.
        script.push_back(script_row(1'b0, ST_OK, CMD_READ, 32'h0020_0000, '0, '0, 2'd0));
        // Punch a two-page hole in the large region and probe inside it and just past it.
        script.push_back(script_row(1'b0, ST_OK, CMD_UNMAP, 32'h0010_1000,
                                    LEN_WIDTH'(2 * PAGE_BYTES), '0, 2'd0));
        script.push_back(script_row(1'b0, ST_OK, CMD_READ, 32'h0010_1800, '0, '0, 2'd0));
        script.push_back(script_row(1'b0, ST_OK, CMD_READ, 32'h0010_3000, '0, '0, 2'd2));
        // Unmap that hits nothing, then one with zero length, then one that frees the entry.
        script.push_back(script_row(1'b0, ST_OK, CMD_UNMAP, 32'h0030_0000, 17'd100, '0, 2'd0));
        script.push_back(script_row(1'b0, ST_OK, CMD_UNMAP, 32'h0020_0000, '0, '0, 2'd0));
        script.push_back(script_row(1'b0, ST_OK, CMD_UNMAP, 32'h0020_0000,
                                    LEN_WIDTH'(MAX_PAGES * PAGE_BYTES), '0, 2'd0));
        // The freed entry is reused; one byte over a page rounds up to two pages.
        script.push_back(script_row(1'b0, ST_OK, CMD_MAP, 32'h0040_0ABC,
                                    LEN_WIDTH'(PAGE_BYTES + 1), PROT_R | PROT_W | PROT_X, 2'd0));
        script.push_back(script_row(1'b0, ST_OK, CMD_READ, 32'h0040_1FFC, '0, '0, 2'd3));
        // Reserved commands answer with an all-zero result.
        script.push_back(script_row(1'b1, ST_OK, CMD_RSVD_LO, '1, '1, '1, 2'd3));
        script.push_back(script_row(1'b1, ST_OK, CMD_RSVD_HI, '1, '1, '1, 2'd3));

        // Synchronous reset, held at the start and never raised again.
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[k]) run_transaction(script[k].txn, script[k].fixed, script[k].want);
        wait_for_drain();

        // Random part. A stretch in the middle runs with no idle cycles at all, and once the
        // sender stops until every outstanding result is back.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idle_on = !(n >= 300 && n < 500);
            if (n == 800) wait_for_drain();
            run_transaction(random_txn(), 1'b0, '0);
        end

        // Let the last results come out; the timeout above bounds this wait.
        wait_for_drain();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
